### rtl/json_string_unescape_utf8_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define JSU_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication whose consequent is checked on the next edge.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/jsu_pkg.sv
package jsu_pkg;

  localparam int HEX_DIGITS  = 4;
  localparam int HEX_VAL_W   = 4 * HEX_DIGITS;
  localparam int HEX_CNT_W   = $clog2(HEX_DIGITS + 1);
  localparam int MAX_RESULTS = 3;
  localparam int SLOT_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // m_axis_tuser layout
  localparam int USER_W      = 4;
  localparam int USER_HAS    = 0;
  localparam int USER_DONE   = 1;
  localparam int USER_ERR_LO = 2;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ESCAPE = 2'd1,
    ERR_HEX    = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [MAX_RESULTS-1:0]      has;
    logic [MAX_RESULTS-1:0][1:0] err;
    logic [SLOT_W-1:0]           last_slot;
    logic                        done;
  } job_t;

endpackage

### rtl/jsu_front.sv
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  input  logic          queue_full,
  output logic          in_ready,
  output logic          push,
  output jsu_pkg::job_t job
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX
  } mode_t;

  mode_t                              mode, mode_next;
  logic [jsu_pkg::HEX_VAL_W-1:0]      hex_value, hex_value_next;
  logic [jsu_pkg::HEX_CNT_W-1:0]      hex_count, hex_count_next;
  logic                               hex_stopped, hex_stopped_next;
  logic [1:0]                         pass_remaining, pass_remaining_next;

  logic                               accept;
  logic                               digit_ok;
  logic [3:0]                         digit;
  logic [7:0]                         digit_tmp;
  logic [jsu_pkg::HEX_VAL_W-1:0]      cv;
  logic [jsu_pkg::SLOT_W-1:0]         n;
  logic                               trunc;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    digit_ok  = 1'b1;
    digit_tmp = 8'h00;
    if (in_byte >= "0" && in_byte <= "9") begin
      digit_tmp = in_byte - 8'h30;
    end else if (in_byte >= "a" && in_byte <= "f") begin
      digit_tmp = in_byte - 8'h57;
    end else if (in_byte >= "A" && in_byte <= "F") begin
      digit_tmp = in_byte - 8'h37;
    end else begin
      digit_ok = 1'b0;
    end
    digit = digit_tmp[3:0];
  end

  always_comb begin
    mode_next           = mode;
    hex_value_next      = hex_value;
    hex_count_next      = hex_count;
    hex_stopped_next    = hex_stopped;
    pass_remaining_next = pass_remaining;
    job                 = '0;
    n                   = '0;
    cv                  = '0;
    trunc               = 1'b0;

    unique case (mode)
      MODE_ESCAPE: begin
        mode_next   = MODE_NORMAL;
        job.has[0]  = 1'b1;
        n           = 2'd1;
        unique case (in_byte)
          "b":  job.data[0] = 8'h08;
          "n":  job.data[0] = 8'h0a;
          "r":  job.data[0] = 8'h0d;
          "f":  job.data[0] = 8'h0c;
          "t":  job.data[0] = 8'h09;
          "\\": job.data[0] = 8'h5c;
          "/":  job.data[0] = 8'h2f;
          "\"": job.data[0] = 8'h22;
          "u": begin
            mode_next        = MODE_HEX;
            hex_value_next   = '0;
            hex_count_next   = '0;
            hex_stopped_next = 1'b0;
            job.has[0]       = 1'b0;
            n                = 2'd0;
          end
          default: begin
            job.has[0] = 1'b0;
            job.err[0] = jsu_pkg::ERR_ESCAPE;
          end
        endcase
      end
      MODE_HEX: begin
        hex_stopped_next = hex_stopped || !digit_ok;
        if (digit_ok && !hex_stopped) begin
          hex_value_next = {hex_value[jsu_pkg::HEX_VAL_W-5:0], digit};
        end
        hex_count_next = hex_count + 1'b1;
        if (hex_count_next >= jsu_pkg::HEX_CNT_W'(jsu_pkg::HEX_DIGITS)) begin
          mode_next = MODE_NORMAL;
          cv        = hex_value_next;
          if (hex_stopped_next) begin
            job.err[0] = jsu_pkg::ERR_HEX;
            n          = 2'd1;
          end else if (cv <= 16'h007f) begin
            job.data[0] = cv[7:0];
            job.has     = 3'b001;
            n           = 2'd1;
          end else if (cv <= 16'h07ff) begin
            job.data[0] = {3'b110, cv[10:6]};
            job.data[1] = {2'b10, cv[5:0]};
            job.has     = 3'b011;
            n           = 2'd2;
          end else begin
            job.data[0] = {4'b1110, cv[15:12]};
            job.data[1] = {2'b10, cv[11:6]};
            job.data[2] = {2'b10, cv[5:0]};
            job.has     = 3'b111;
            n           = 2'd3;
          end
          hex_value_next   = '0;
          hex_count_next   = '0;
          hex_stopped_next = 1'b0;
        end
      end
      default: begin
        job.data[0] = in_byte;
        job.has[0]  = 1'b1;
        n           = 2'd1;
        if (pass_remaining != 2'd0) begin
          pass_remaining_next = pass_remaining - 2'd1;
        end else if (in_byte >= 8'hc0 && in_byte <= 8'hdf) begin
          pass_remaining_next = 2'd1;
        end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
          pass_remaining_next = 2'd2;
        end else if (in_byte >= 8'hf0 && in_byte <= 8'hf7) begin
          pass_remaining_next = 2'd3;
        end else if (in_byte == 8'h5c) begin
          mode_next   = MODE_ESCAPE;
          job.data[0] = 8'h00;
          job.has[0]  = 1'b0;
          n           = 2'd0;
        end
      end
    endcase

    // Close the string: mark it done, flag any pending sequence, go idle.
    if (in_end) begin
      trunc = (mode_next != MODE_NORMAL) || (pass_remaining_next != 2'd0);
      if (trunc || n == 2'd0) begin
        job.err[n] = trunc ? jsu_pkg::ERR_TRUNC : jsu_pkg::ERR_NONE;
        n          = n + 2'd1;
      end
      job.done            = 1'b1;
      mode_next           = MODE_NORMAL;
      hex_value_next      = '0;
      hex_count_next      = '0;
      hex_stopped_next    = 1'b0;
      pass_remaining_next = 2'd0;
    end
    job.last_slot = n - 2'd1;
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      hex_value      <= '0;
      hex_count      <= '0;
      hex_stopped    <= 1'b0;
      pass_remaining <= 2'd0;
    end else if (accept) begin
      mode           <= mode_next;
      hex_value      <= hex_value_next;
      hex_count      <= hex_count_next;
      hex_stopped    <= hex_stopped_next;
      pass_remaining <= pass_remaining_next;
    end
  end

endmodule

### rtl/jsu_queue.sv
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output jsu_pkg::job_t head
);

  jsu_pkg::job_t                   mem [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QUEUE_CNT_W-1:0] count;
  logic                            do_push, do_pop;

  assign full    = (count == jsu_pkg::QUEUE_CNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/jsu_back.sv
module jsu_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        queue_valid,
  input  jsu_pkg::job_t               head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_data,
  output logic                        out_last,
  output logic [jsu_pkg::USER_W-1:0]  out_user
);

  jsu_pkg::job_t              cur;
  logic                       cur_valid;
  logic [jsu_pkg::SLOT_W-1:0] idx;
  logic                       fire, last;

  assign out_valid = cur_valid;
  assign last      = (idx == cur.last_slot);
  assign fire      = out_valid && out_ready;
  assign pop       = queue_valid && (!cur_valid || (fire && last));

  assign out_data = cur.data[idx];
  assign out_last = last;
  assign out_user = {cur.err[idx], cur.done && last, cur.has[idx]};

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fire && last) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (fire) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

### rtl/json_string_unescape_utf8.sv
// Unescapes a JSON string body, one raw byte per request on s_axis, and
// streams the unescaped bytes on m_axis. A byte is taken every cycle while
// the four-entry job queue between the parser and the output stage has room;
// each request yields zero to three results, and the output stage sends one
// result per cycle while m_axis_tready is high. An accepted byte's results
// pass through the job queue and the output stage's job register. m_axis_tlast
// marks the last result caused by one input byte; the string's final result
// also has the done bit set in m_axis_tuser. Status-only results carry zero
// data and either the done bit alone or an error code: unknown escape, bad
// hex digit, or a string that ended inside an escape, hex digits or a UTF-8
// sequence.
module json_string_unescape_utf8 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
  input  logic                       s_axis_tlast,   // end_of_string
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // run_last
  output logic [jsu_pkg::USER_W-1:0] m_axis_tuser    // [0] has_byte, [1] string_done,
                                                     // [3:2] error_code
);

  logic          queue_full, queue_valid, push, pop;
  jsu_pkg::job_t push_job, head;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .queue_full (queue_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .job        (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .valid    (queue_valid),
    .head     (head)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (queue_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_user    (m_axis_tuser)
  );

endmodule

### rtl/jsu_checker.sv
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [7:0]                 m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic [jsu_pkg::USER_W-1:0] m_axis_tuser
);

  logic [1:0]                  err;
  logic                        has, done, stall, status_ok, err_ok;
  logic [jsu_pkg::USER_W+8:0]  beat;

  assign err       = m_axis_tuser[jsu_pkg::USER_ERR_LO +: 2];
  assign has       = m_axis_tuser[jsu_pkg::USER_HAS];
  assign done      = m_axis_tuser[jsu_pkg::USER_DONE];
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign beat      = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign status_ok = (m_axis_tdata == 8'h00) && (err != jsu_pkg::ERR_NONE || done);
  assign err_ok    = (!has || err == jsu_pkg::ERR_NONE) && (err != jsu_pkg::ERR_TRUNC || done);

  // Hold a stalled result unchanged.
  `JSU_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(beat), "stalled result changed")

  // The string's final result also closes its run.
  `JSU_ASSERT_NOW(a_done_last, !(m_axis_tvalid && done) || m_axis_tlast, "done without run end")

  // A status result carries zero data and either an error or the done mark.
  `JSU_ASSERT_NOW(a_status_form, !m_axis_tvalid || has || status_ok, "malformed status result")

  // Data results never carry an error; truncation only ends a string.
  `JSU_ASSERT_NOW(a_err_place, !m_axis_tvalid || err_ok, "error on wrong result")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
